// File: design/pbsp_pkg.sv
package pbsp_pkg;

  localparam int POS_BITS  = 32;
  localparam int MAX_NEST  = 4;
  localparam int DEPTH_W   = $clog2(MAX_NEST + 1);
  localparam int IDX_W     = $clog2(MAX_NEST);
  localparam int FIELD_W   = 29;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [2:0] {
    PH_KEY     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_FIXED   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5,
    PH_PACKED  = 3'd6
  } phase_t;

  localparam logic [2:0] TK_VARINT  = 3'd0;
  localparam logic [2:0] TK_FIXED32 = 3'd1;
  localparam logic [2:0] TK_FIXED64 = 3'd2;
  localparam logic [2:0] TK_BYTE    = 3'd3;
  localparam logic [2:0] TK_OPEN    = 3'd4;
  localparam logic [2:0] TK_CLOSE   = 3'd5;
  localparam logic [2:0] TK_ERROR   = 3'd6;

  localparam logic [2:0] CTX_MODEL = 3'd0;
  localparam logic [2:0] CTX_GRAPH = 3'd1;
  localparam logic [2:0] CTX_NODE  = 3'd2;
  localparam logic [2:0] CTX_TENSOR = 3'd3;
  localparam logic [2:0] CTX_ATTR  = 3'd4;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  localparam logic [3:0] ACT_SKIP   = 4'd0;
  localparam logic [3:0] ACT_EMIT   = 4'd1;
  localparam logic [3:0] ACT_PACKED = 4'd2;
  localparam logic [3:0] ACT_OPEN   = 4'd8;

  typedef struct packed {
    phase_t                phase;
    logic [63:0]           acc;
    logic [3:0]            cnt;
    logic [FIELD_W-1:0]    fld;
    logic [2:0]            wtype;
    logic [POS_BITS-1:0]   rem;
    logic [POS_BITS-1:0]   pos;
    logic [DEPTH_W-1:0]    depth;
    logic                  halted;
  } pstate_t;

  typedef struct packed {
    logic                push;
    logic [POS_BITS-1:0] push_end;
    logic [2:0]          push_ctx;
  } push_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         ctx;
    logic [FIELD_W-1:0] fld;
    logic [2:0]         wtype;
    logic [63:0]        value;
    logic               last;
    logic [2:0]         closed;
  } token_t;

  function automatic logic [3:0] classify(input logic [2:0] ctx,
                                          input logic [FIELD_W-1:0] f,
                                          input logic [2:0] w);
    logic [3:0] act;
    act = ACT_SKIP;
    case (ctx)
      CTX_MODEL: begin
        if (f == 29'd1 && w == WT_LEN) act = ACT_OPEN + 4'(CTX_GRAPH);
      end
      CTX_GRAPH: begin
        if (f == 29'd1 && w == WT_LEN) act = ACT_OPEN + 4'(CTX_NODE);
        else if (f == 29'd5 && w == WT_LEN) act = ACT_OPEN + 4'(CTX_TENSOR);
      end
      CTX_NODE: begin
        if (f >= 29'd1 && f <= 29'd4 && w == WT_LEN) act = ACT_EMIT;
        else if (f == 29'd5 && w == WT_LEN) act = ACT_OPEN + 4'(CTX_ATTR);
      end
      CTX_TENSOR: begin
        if (f == 29'd1 && w == WT_VARINT) act = ACT_EMIT;
        else if ((f == 29'd8 || f == 29'd9) && w == WT_LEN) act = ACT_EMIT;
      end
      CTX_ATTR: begin
        if (f == 29'd1 && w == WT_LEN) act = ACT_EMIT;
        else if (f == 29'd2 && w == WT_VARINT) act = ACT_EMIT;
        else if (f == 29'd4 && w == WT_FIX32) act = ACT_EMIT;
        else if (f == 29'd7 && w == WT_LEN) act = ACT_PACKED;
      end
      default: act = ACT_SKIP;
    endcase
    return act;
  endfunction

endpackage

// File: design/pbsp_step.sv
module pbsp_step
  import pbsp_pkg::*;
(
  input  pstate_t                          st,
  input  logic [MAX_NEST-1:0][POS_BITS-1:0] lend,
  input  logic [MAX_NEST-1:0][2:0]          lctx,
  input  logic                             emit_skipped,
  input  logic [7:0]                       in_byte,
  input  logic                             eos,
  output pstate_t                          nst,
  output push_t                            psh,
  output logic                             have_tok,
  output token_t                           tok
);

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic [IDX_W-1:0]      top_idx;
  logic [2:0]            ctx;
  logic [POS_BITS-1:0]   lim, room, pos1, rem_dec;
  logic [63:0]           vacc, len;
  logic [6:0]            shamt;
  logic                  vdone, vover;
  logic [3:0]            act;
  logic                  perr, err, have, boundary, any_hit;
  logic [2:0]            kind;
  logic [63:0]           value;
  logic                  last;
  logic [MAX_NEST-1:0][POS_BITS-1:0] e;
  logic [MAX_NEST-1:0][2:0]          c;
  logic [MAX_NEST-1:0]               hit;
  logic [2:0]            closed;
  logic [DEPTH_W-1:0]    d2, dfin;
  logic [IDX_W-1:0]      fin_idx;
  logic [2:0]            ctx_fin;

  always_comb begin
    top_idx = IDX_W'(st.depth - DEPTH_W'(1));
    ctx  = (st.depth == '0) ? CTX_MODEL : lctx[top_idx];
    lim  = (st.depth == '0) ? POS_MAX : lend[top_idx];
    pos1 = st.pos + POS_BITS'(1);
    room = (lim >= pos1) ? lim - pos1 : '0;
    rem_dec = (st.rem != '0) ? st.rem - POS_BITS'(1) : '0;
    shamt = 7'(st.cnt) * 7'd7;
    vacc  = st.acc;
    if (st.cnt < 4'd10) vacc = st.acc | (64'(in_byte[6:0]) << shamt[5:0]);
    vdone = ~in_byte[7];
    vover = in_byte[7] && (st.cnt >= 4'd9);
    len   = '0;
    act   = ACT_SKIP;

    nst   = st;
    psh   = '0;
    perr  = 1'b0;
    have  = 1'b0;
    kind  = TK_VARINT;
    value = '0;
    last  = 1'b0;

    if (st.pos == POS_MAX) begin
      perr = 1'b1;
    end else begin
      nst.pos = pos1;
      case (st.phase)
        PH_KEY, PH_VARINT, PH_LENGTH: begin
          nst.acc = vacc;
          if (!vdone) begin
            nst.cnt = st.cnt + 4'd1;
            if (vover) perr = 1'b1;
          end else begin
            nst.acc = '0;
            nst.cnt = '0;
            nst.phase = PH_KEY;
            if (st.phase == PH_KEY) begin
              nst.fld   = vacc[FIELD_W+2:3];
              nst.wtype = vacc[2:0];
              if (vacc[2:0] == WT_VARINT) nst.phase = PH_VARINT;
              else if (vacc[2:0] == WT_LEN) nst.phase = PH_LENGTH;
              else if (vacc[2:0] == WT_FIX64 || vacc[2:0] == WT_FIX32) begin
                len = (vacc[2:0] == WT_FIX64) ? 64'd8 : 64'd4;
                if (len > 64'(room)) perr = 1'b1;
                nst.rem = POS_BITS'(len);
                nst.phase = PH_FIXED;
              end
            end else if (st.phase == PH_VARINT) begin
              if (classify(ctx, st.fld, WT_VARINT) == ACT_EMIT || emit_skipped) begin
                have = 1'b1; kind = TK_VARINT; value = vacc;
              end
            end else begin
              len = vacc;
              act = classify(ctx, st.fld, WT_LEN);
              if (len > 64'(room)) perr = 1'b1;
              else if (act >= ACT_OPEN) begin
                if (st.depth >= DEPTH_W'(MAX_NEST)) perr = 1'b1;
                else begin
                  have = 1'b1; kind = TK_OPEN; value = len;
                  psh.push     = 1'b1;
                  psh.push_end = pos1 + POS_BITS'(len);
                  psh.push_ctx = act[2:0];
                  nst.depth    = st.depth + DEPTH_W'(1);
                end
              end else if (len != '0) begin
                nst.rem = POS_BITS'(len);
                if (act == ACT_PACKED) nst.phase = PH_PACKED;
                else if (act == ACT_EMIT || emit_skipped) nst.phase = PH_PAYLOAD;
                else nst.phase = PH_SKIP;
              end
            end
          end
        end
        PH_FIXED: begin
          nst.acc = st.acc | (64'(in_byte) << {st.cnt[2:0], 3'b000});
          nst.cnt = st.cnt + 4'd1;
          nst.rem = rem_dec;
          if (rem_dec == '0) begin
            if (classify(ctx, st.fld, st.wtype) == ACT_EMIT || emit_skipped) begin
              have = 1'b1;
              kind = (st.wtype == WT_FIX32) ? TK_FIXED32 : TK_FIXED64;
              value = nst.acc;
            end
            nst.acc = '0;
            nst.cnt = '0;
            nst.phase = PH_KEY;
          end
        end
        PH_PAYLOAD, PH_SKIP: begin
          nst.rem = rem_dec;
          if (st.phase == PH_PAYLOAD) begin
            have = 1'b1; kind = TK_BYTE; value = 64'(in_byte); last = (rem_dec == '0);
          end
          if (rem_dec == '0) nst.phase = PH_KEY;
        end
        PH_PACKED: begin
          nst.rem = rem_dec;
          if (vover) perr = 1'b1;
          else if (vdone) begin
            have = 1'b1; kind = TK_VARINT; value = vacc; last = (rem_dec == '0);
            nst.acc = '0;
            nst.cnt = '0;
            if (rem_dec == '0) nst.phase = PH_KEY;
          end else begin
            nst.acc = vacc;
            nst.cnt = st.cnt + 4'd1;
            if (rem_dec == '0) perr = 1'b1;
          end
        end
        default: begin
          nst.phase = PH_KEY;
          nst.acc = '0;
          nst.cnt = '0;
        end
      endcase
    end

    // stack view including this beat's push; ends are nested so hits are the top run
    for (int i = 0; i < MAX_NEST; i++) begin
      e[i] = (psh.push && st.depth == DEPTH_W'(i)) ? psh.push_end : lend[i];
      c[i] = (psh.push && st.depth == DEPTH_W'(i)) ? psh.push_ctx : lctx[i];
      hit[i] = (DEPTH_W'(i) < nst.depth) && (nst.pos >= e[i]);
    end
    any_hit  = |hit;
    boundary = (nst.phase == PH_KEY) && (nst.cnt == '0);
    closed   = '0;
    err      = perr;
    if (!perr) begin
      if (boundary) closed = 3'($countones(hit));
      else if (any_hit) err = 1'b1;
    end
    d2 = nst.depth - DEPTH_W'(closed);
    if (!err && eos) begin
      if (boundary && d2 == '0) nst.pos = '0;
      else err = 1'b1;
    end
    nst.depth = d2;
    dfin = perr ? st.depth : d2;
    fin_idx = IDX_W'(dfin - DEPTH_W'(1));
    ctx_fin = (dfin == '0) ? CTX_MODEL : c[fin_idx];
    if (err) nst.halted = 1'b1;

    have_tok = err || have || (closed != '0);
    tok = '0;
    if (err) begin
      tok.kind   = TK_ERROR;
      tok.ctx    = ctx_fin;
      tok.fld    = nst.fld;
      tok.wtype  = nst.wtype;
    end else if (have) begin
      tok.kind   = kind;
      tok.ctx    = ctx;
      tok.fld    = nst.fld;
      tok.wtype  = nst.wtype;
      tok.value  = value;
      tok.last   = last;
      tok.closed = closed;
    end else begin
      tok.kind   = TK_CLOSE;
      tok.ctx    = ctx_fin;
      tok.closed = closed;
    end
  end

endmodule

// File: design/protobuf_model_stream_parser.sv
// Latency: a result appears on the master side the cycle after its input beat.
// Throughput: one input beat per cycle; the input side stalls only while a
// held result is not taken.
// Reset (rst, synchronous): parser idle at key, position and depth zero,
// output empty, emit_skipped cleared. The nesting stack is not cleared.
module protobuf_model_stream_parser
  import pbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // in_byte
  input  logic                  s_tlast,   // end_of_stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // context_res, field_number, wtype,
                                           // field_value, levels_closed, zero pad
  output logic [2:0]            m_tuser,   // token_kind
  output logic                  m_tlast,   // last_of_field
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_data   // emit_skipped
);

  pstate_t st, st_next;
  push_t   psh;
  token_t  tok, out_tok;
  logic    have_tok;
  logic    emit_skipped;
  logic    accept;
  logic [MAX_NEST-1:0][POS_BITS-1:0] level_end;
  logic [MAX_NEST-1:0][2:0]          level_ctx;

  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  pbsp_step u_step (
    .st           (st),
    .lend         (level_end),
    .lctx         (level_ctx),
    .emit_skipped (emit_skipped),
    .in_byte      (s_tdata),
    .eos          (s_tlast),
    .nst          (st_next),
    .psh          (psh),
    .have_tok     (have_tok),
    .tok          (tok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      emit_skipped <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) emit_skipped <= cfg_data[0];
      if (accept && !st.halted) st <= st_next;
      if (accept && !st.halted && have_tok) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !st.halted) begin
      if (psh.push) begin
        level_end[IDX_W'(st.depth)] <= psh.push_end;
        level_ctx[IDX_W'(st.depth)] <= psh.push_ctx;
      end
      if (have_tok) out_tok <= tok;
    end
  end

  assign m_tuser = out_tok.kind;
  assign m_tlast = out_tok.last;
  assign m_tdata = {2'b00, out_tok.closed, out_tok.value, out_tok.wtype,
                    out_tok.fld, out_tok.ctx};

endmodule
